// File: hw/rtl/gfmp_pkg.sv
// gfmp_pkg: shared types and field arithmetic for the gf(2^8) matrix power block
// used by gf256_matrix_power and gfmp_mac; no dependencies
`timescale 1ns / 1ps

package gfmp_pkg;

  // low byte of the aes reduction polynomial x^8+x^4+x^3+x+1
  localparam logic [7:0] GF_POLY = 8'h1B;

  // control that travels with one multiply-accumulate beat
  typedef struct packed {
    logic valid;
    logic first;
    logic last;
  } mac_ctl_t;

  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] x;
    logic [7:0] p;
    x = a;
    p = 8'h00;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) begin
        p = p ^ x;
      end
      x = {x[6:0], 1'b0} ^ (x[7] ? GF_POLY : 8'h00);
    end
    return p;
  endfunction

endpackage

// File: hw/rtl/gfmp_mac.sv
// gfmp_mac: shared gf(2^8) multiply-accumulate unit for one dot product at a time
// depends on gfmp_pkg
`timescale 1ns / 1ps

module gfmp_mac #(
  parameter int AW = 6
) (
  input  logic              clk,
  input  gfmp_pkg::mac_ctl_t ctl,
  input  logic [AW-1:0]     addr,
  input  logic [7:0]        lhs,
  input  logic [7:0]        rhs,
  output logic              wr_en,
  output logic [AW-1:0]     wr_addr,
  output logic [7:0]        wr_data
);

  logic [7:0] sum_r;
  logic [7:0] sum_nxt;

  assign sum_nxt = (ctl.first ? 8'h00 : sum_r) ^ gfmp_pkg::gf_mul(lhs, rhs);

  always_ff @(posedge clk) begin
    if (ctl.valid) begin
      sum_r <= sum_nxt;
    end
  end

  assign wr_en   = ctl.valid & ctl.last;
  assign wr_addr = addr;
  assign wr_data = sum_nxt;

endmodule

// File: hw/rtl/gf256_matrix_power.sv
// gf256_matrix_power: raises a loaded DIM x DIM matrix over gf(2^8) to a power
// depends on gfmp_pkg and gfmp_mac
// load beats leave busy low; a compute beat holds busy through an identity init pass,
// a multiply pass and a copy pass per step, then the result pass, CELLS = DIM*DIM,
// with one product per set exponent bit and one squaring per bit below the top one,
// all on the single multiply-accumulate unit; result beats come one per cycle, no stall
// reset is synchronous active low and clears control only; matrix memories are not cleared
`timescale 1ns / 1ps

module gf256_matrix_power #(
  parameter int DIM = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_action,
  input  logic [7:0]  in_element,
  input  logic [30:0] in_exponent,
  output logic        out_valid,
  output logic [7:0]  out_element_out,
  output logic        out_last
);

  localparam int CELLS = DIM * DIM;
  localparam int AW    = $clog2(CELLS);
  localparam int KW    = $clog2(DIM);
  localparam logic [AW-1:0] LAST_A = AW'(CELLS - 1);
  localparam logic [AW-1:0] DIM_A  = AW'(DIM);
  localparam logic [AW-1:0] DIMM_A = AW'(DIM - 1);
  localparam logic [KW-1:0] LAST_K = KW'(DIM - 1);

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_INIT   = 6'b000010,
    ST_DECIDE = 6'b000100,
    ST_MUL    = 6'b001000,
    ST_COPY   = 6'b010000,
    ST_OUT    = 6'b100000
  } state_t;

  state_t        state_r, state_nxt;
  logic [AW-1:0] load_r, load_nxt;
  logic [30:0]   exp_r, exp_nxt;
  logic [AW-1:0] cnt_r, cnt_nxt;
  logic [KW-1:0] k_r, k_nxt;
  logic [KW-1:0] col_r, col_nxt;
  logic [AW-1:0] lhs_r, lhs_nxt;
  logic [AW-1:0] rhs_r, rhs_nxt;
  logic [AW-1:0] dst_r, dst_nxt;
  logic          sq_r, sq_nxt;

  logic          cp_valid_r;
  logic          cp_init_r;
  logic [AW-1:0] cp_addr_r;
  gfmp_pkg::mac_ctl_t mac_ctl_r;
  logic [AW-1:0] mac_addr_r;
  logic          ov_r;
  logic          ol_r;

  logic [7:0] base_mem [CELLS];
  logic [7:0] acc_mem  [CELLS];
  logic [7:0] pw_mem   [CELLS];
  logic [7:0] scr_mem  [CELLS];

  logic [7:0] base_rd_r;
  logic [7:0] acc_rd_r;
  logic [7:0] pwa_rd_r;
  logic [7:0] pwb_rd_r;
  logic [7:0] scr_rd_r;

  logic          is_mul;
  logic          cnt_last;
  logic          k_last;
  logic          col_last;
  logic          load_beat;
  logic [AW-1:0] acc_ra;
  logic          mac_we;
  logic [AW-1:0] mac_wa;
  logic [7:0]    mac_wd;

  assign is_mul    = (state_r == ST_MUL);
  assign cnt_last  = (cnt_r == LAST_A);
  assign k_last    = (k_r == LAST_K);
  assign col_last  = (col_r == LAST_K);
  assign load_beat = (state_r == ST_IDLE) && start && !in_action;
  assign acc_ra    = is_mul ? lhs_r : cnt_r;

  always_comb begin
    state_nxt = state_r;
    load_nxt  = load_r;
    exp_nxt   = exp_r;
    cnt_nxt   = cnt_r;
    k_nxt     = k_r;
    col_nxt   = col_r;
    lhs_nxt   = lhs_r;
    rhs_nxt   = rhs_r;
    dst_nxt   = dst_r;
    sq_nxt    = sq_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          if (in_action) begin
            load_nxt  = '0;
            exp_nxt   = in_exponent;
            cnt_nxt   = '0;
            k_nxt     = '0;
            col_nxt   = '0;
            state_nxt = ST_INIT;
          end else begin
            load_nxt = (load_r == LAST_A) ? '0 : load_r + 1'b1;
          end
        end
      end
      ST_INIT: begin
        if (col_last) begin
          col_nxt = '0;
          k_nxt   = k_r + 1'b1;
        end else begin
          col_nxt = col_r + 1'b1;
        end
        if (cnt_last) begin
          cnt_nxt   = '0;
          state_nxt = ST_DECIDE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_DECIDE: begin
        lhs_nxt = '0;
        rhs_nxt = '0;
        dst_nxt = '0;
        k_nxt   = '0;
        col_nxt = '0;
        cnt_nxt = '0;
        if (exp_r == '0) begin
          state_nxt = ST_OUT;
        end else begin
          sq_nxt    = !exp_r[0];
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        if (k_last) begin
          k_nxt   = '0;
          dst_nxt = dst_r + 1'b1;
          if (col_last) begin
            col_nxt = '0;
            lhs_nxt = lhs_r + 1'b1;
            rhs_nxt = '0;
          end else begin
            col_nxt = col_r + 1'b1;
            lhs_nxt = lhs_r - DIMM_A;
            rhs_nxt = AW'(col_r) + 1'b1;
          end
          if (dst_r == LAST_A) begin
            cnt_nxt   = '0;
            state_nxt = ST_COPY;
          end
        end else begin
          k_nxt   = k_r + 1'b1;
          lhs_nxt = lhs_r + 1'b1;
          rhs_nxt = rhs_r + DIM_A;
        end
      end
      ST_COPY: begin
        if (cnt_last) begin
          cnt_nxt   = '0;
          state_nxt = ST_DECIDE;
          if (sq_r) begin
            exp_nxt = exp_r >> 1;
          end else begin
            exp_nxt = {exp_r[30:1], 1'b0};
          end
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_OUT: begin
        if (cnt_last) begin
          cnt_nxt   = '0;
          state_nxt = ST_IDLE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      load_r     <= '0;
      exp_r      <= '0;
      cp_valid_r <= 1'b0;
      mac_ctl_r  <= '0;
      ov_r       <= 1'b0;
      ol_r       <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      load_r     <= load_nxt;
      exp_r      <= exp_nxt;
      cp_valid_r <= (state_r == ST_INIT) || (state_r == ST_COPY);
      mac_ctl_r  <= '{valid: is_mul, first: (k_r == '0), last: k_last};
      ov_r       <= (state_r == ST_OUT);
      ol_r       <= (state_r == ST_OUT) && cnt_last;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r      <= cnt_nxt;
    k_r        <= k_nxt;
    col_r      <= col_nxt;
    lhs_r      <= lhs_nxt;
    rhs_r      <= rhs_nxt;
    dst_r      <= dst_nxt;
    sq_r       <= sq_nxt;
    cp_init_r  <= (state_r == ST_INIT);
    cp_addr_r  <= cnt_r;
    mac_addr_r <= dst_r;
  end

  // base matrix: loaded beats in, read once per compute to seed the power
  always_ff @(posedge clk) begin
    if (load_beat) begin
      base_mem[load_r] <= in_element;
    end
    base_rd_r <= base_mem[cnt_r];
  end

  // running product, starts as identity
  always_ff @(posedge clk) begin
    if (state_r == ST_INIT) begin
      acc_mem[cnt_r] <= (k_r == col_r) ? 8'h01 : 8'h00;
    end else if (cp_valid_r && !cp_init_r && !sq_r) begin
      acc_mem[cp_addr_r] <= scr_rd_r;
    end
    acc_rd_r <= acc_mem[acc_ra];
  end

  // repeated squares of the base
  always_ff @(posedge clk) begin
    if (cp_valid_r && (cp_init_r || sq_r)) begin
      pw_mem[cp_addr_r] <= cp_init_r ? base_rd_r : scr_rd_r;
    end
    pwa_rd_r <= pw_mem[lhs_r];
    pwb_rd_r <= pw_mem[rhs_r];
  end

  // product buffer
  always_ff @(posedge clk) begin
    if (mac_we) begin
      scr_mem[mac_wa] <= mac_wd;
    end
    scr_rd_r <= scr_mem[cnt_r];
  end

  gfmp_mac #(
    .AW(AW)
  ) u_mac (
    .clk     (clk),
    .ctl     (mac_ctl_r),
    .addr    (mac_addr_r),
    .lhs     (sq_r ? pwa_rd_r : acc_rd_r),
    .rhs     (pwb_rd_r),
    .wr_en   (mac_we),
    .wr_addr (mac_wa),
    .wr_data (mac_wd)
  );

  assign busy            = (state_r != ST_IDLE);
  assign out_valid       = ov_r;
  assign out_last        = ol_r;
  assign out_element_out = acc_rd_r;

endmodule

// File: hw/rtl/gfmp_chk.sv
// gfmp_chk: port-level checks for gf256_matrix_power, bound to the top level
// depends on gf256_matrix_power ports only
`timescale 1ns / 1ps

module gfmp_chk (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic in_action,
  input logic out_valid,
  input logic out_last
);

  // last marks a real beat
  a_last_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_last |-> out_valid)
    else $error("out_last without out_valid");

  // a compute beat makes the block busy
  a_cmp_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_action) |=> busy)
    else $error("compute beat did not raise busy");

  // a load beat never makes the block busy
  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && !in_action) |=> (!busy && !out_valid))
    else $error("load beat raised busy or produced a result");

  // result beats of one matrix are back to back
  a_out_run: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last) |=> out_valid)
    else $error("gap inside result matrix");

  // block stays busy until the final beat
  a_out_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last) |-> busy)
    else $error("busy dropped before the final beat");

endmodule

bind gf256_matrix_power gfmp_chk u_gfmp_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_action (in_action),
  .out_valid (out_valid),
  .out_last  (out_last)
);

// File: test/tb_top.sv
// tb_top: self-checking testbench for gf256_matrix_power (gf(2^8) matrix power)
// depends on the gf256_matrix_power rtl only; holds its own square-and-multiply predictor
`timescale 1ns / 1ps

module tb_top;

  localparam int DIM   = 8;
  localparam int CELLS = DIM * DIM;
  localparam int BEATS = 380;

  typedef bit [7:0] gmat_t [CELLS];

  typedef struct packed {
    logic [7:0] element;
    logic       last;
  } mat_byte_t;

  class gf_power_scoreboard;
    bit [7:0]    base_m [CELLS];
    int unsigned load_pos;
    int unsigned errors;
    mat_byte_t   pending_q [$];

    function new();
      load_pos = 0;
      errors   = 0;
      foreach (base_m[i]) base_m[i] = 8'h00;
    endfunction

    // carry-less product, then fold down by x^8+x^4+x^3+x+1
    function bit [7:0] gf_times(bit [7:0] a, bit [7:0] b);
      bit [15:0] wide;
      wide = 16'h0000;
      for (int i = 0; i < 8; i++) begin
        if (b[i]) wide ^= 16'(a) << i;
      end
      for (int i = 15; i >= 8; i--) begin
        if (wide[i]) wide ^= 16'h011B << (i - 8);
      end
      return wide[7:0];
    endfunction

    function gmat_t mat_product(gmat_t a, gmat_t b);
      gmat_t    prod;
      bit [7:0] sum;
      for (int r = 0; r < DIM; r++) begin
        for (int c = 0; c < DIM; c++) begin
          sum = 8'h00;
          for (int k = 0; k < DIM; k++) sum ^= gf_times(a[r*DIM+k], b[k*DIM+c]);
          prod[r*DIM+c] = sum;
        end
      end
      return prod;
    endfunction

    function void note_input(bit act, bit [7:0] el, bit [30:0] ex);
      gmat_t      acc;
      gmat_t      pw;
      bit [30:0]  e;
      mat_byte_t  rb;
      if (act == 1'b0) begin
        base_m[load_pos] = el;
        load_pos = (load_pos + 1) % CELLS;
        return;
      end
      load_pos = 0;
      foreach (acc[i]) acc[i] = ((i / DIM) == (i % DIM)) ? 8'h01 : 8'h00;
      pw = base_m;
      e  = ex;
      while (e != 0) begin
        if (e[0]) acc = mat_product(acc, pw);
        if (e > 1) pw = mat_product(pw, pw);
        e = e >> 1;
      end
      for (int i = 0; i < CELLS; i++) begin
        rb.element = acc[i];
        rb.last    = (i == CELLS - 1);
        pending_q.push_back(rb);
      end
    endfunction

    function void check_result(bit [7:0] el, bit lst);
      mat_byte_t want;
      if (pending_q.size() == 0) begin
        $error("unexpected result beat: element_out %0h last %0b", el, lst);
        errors++;
        return;
      end
      want = pending_q.pop_front();
      if (el != want.element) begin
        $error("element_out: expected %0h, actual %0h", want.element, el);
        errors++;
      end
      if (lst != want.last) begin
        $error("last: expected %0b, actual %0b", want.last, lst);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic        in_action;
  logic [7:0]  in_element;
  logic [30:0] in_exponent;
  logic        out_valid;
  logic [7:0]  out_element_out;
  logic        out_last;

  gf_power_scoreboard sb;
  int unsigned        idle_pct;
  int unsigned        sent;
  int unsigned        big_left;

  gf256_matrix_power #(
    .DIM(DIM)
  ) u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_action      (in_action),
    .in_element     (in_element),
    .in_exponent    (in_exponent),
    .out_valid      (out_valid),
    .out_element_out(out_element_out),
    .out_last       (out_last)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // run limit, far above the slowest legal run of this stimulus
  initial begin
    #20000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && start && !busy) sb.note_input(in_action, in_element, in_exponent);
    if (rst_n && out_valid) sb.check_result(out_element_out, out_last);
  end

  // present one beat, idling first at the current rate, and hold until accepted
  task automatic send_beat(input bit act, input bit [7:0] el, input bit [30:0] ex);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start       <= 1'b1;
    in_action   <= act;
    in_element  <= el;
    in_exponent <= ex;
    @(posedge clk);
    while (busy) @(posedge clk);
    sent++;
  endtask

  // mostly short exponents, a handful spanning all 31 bits
  function automatic bit [30:0] pick_exponent();
    int unsigned s;
    s = $urandom_range(9);
    if (s == 0 && big_left > 0) begin
      big_left--;
      return 31'($urandom);
    end
    if (s < 4) return 31'($urandom_range(0, 3));
    return 31'($urandom_range(0, 255));
  endfunction

  initial begin
    int unsigned idle_tbl [4];
    int unsigned seq_no;
    int unsigned nload;
    int unsigned ncomp;
    bit          act;

    idle_tbl    = '{0, 83, 0, 36};
    sb          = new();
    rst_n       = 1'b0;
    start       = 1'b0;
    in_action   = 1'b0;
    in_element  = 8'h00;
    in_exponent = 31'd0;
    idle_pct    = 0;
    sent        = 0;
    big_left    = 6;
    seq_no      = 0;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // full load with extreme bytes, junk exponents on loads
    for (int i = 0; i < CELLS; i++) begin
      send_beat(1'b0, (i == 0) ? 8'h00 : (i == 1) ? 8'hFF : 8'(i * 29 + 3),
                (i % 2) ? 31'h7FFFFFFF : 31'd0);
    end
    send_beat(1'b1, 8'hFF, 31'd0);
    send_beat(1'b1, 8'h00, 31'd1);
    send_beat(1'b1, 8'hA5, 31'd2);
    send_beat(1'b1, 8'h00, 31'h7FFFFFFF);
    send_beat(1'b1, 8'h00, 31'h40000000);
    // partial load over the old base
    send_beat(1'b0, 8'hFF, 31'd5);
    send_beat(1'b0, 8'h80, 31'd0);
    send_beat(1'b0, 8'h01, 31'd0);
    send_beat(1'b1, 8'h00, 31'd3);

    while (sent < BEATS) begin
      idle_pct = idle_tbl[seq_no % 4];
      seq_no++;
      if ($urandom_range(99) < 75) begin
        // full matrix, sometimes running past the end so the index wraps
        nload = CELLS;
        if ($urandom_range(4) == 0) nload += $urandom_range(1, 8);
        for (int i = 0; i < nload; i++) send_beat(1'b0, 8'($urandom), 31'($urandom));
        ncomp = $urandom_range(1, 2);
        for (int i = 0; i < ncomp; i++) send_beat(1'b1, 8'($urandom), pick_exponent());
      end else begin
        nload = $urandom_range(1, 12);
        for (int i = 0; i < nload; i++) begin
          act = ($urandom_range(3) == 0);
          send_beat(act, 8'($urandom), act ? pick_exponent() : 31'($urandom));
        end
      end
    end
    start <= 1'b0;

    @(posedge clk);
    while (busy || sb.pending_q.size() != 0) @(posedge clk);
    repeat (2 * CELLS) @(posedge clk);
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// File: sim.f
hw/rtl/gfmp_pkg.sv
hw/rtl/gfmp_mac.sv
hw/rtl/gf256_matrix_power.sv
hw/rtl/gfmp_chk.sv
test/tb_top.sv
